// ===== rtl/core/sparse_matrix_entry_store_defines.svh =====
// Assertion macros shared by the coordinate store.
`ifndef SPARSE_MATRIX_ENTRY_STORE_DEFINES_SVH
`define SPARSE_MATRIX_ENTRY_STORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SMES_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SMES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/smes_pkg.sv =====
package smes_pkg;

    localparam int ROW_W   = 10;
    localparam int COL_W   = 10;
    localparam int VAL_W   = 32;
    localparam int DIM_W   = 11;
    localparam int ENTRY_W = ROW_W + COL_W + VAL_W;

    localparam int ENTRIES_DEFAULT = 64;
    localparam int MAX_ROWS        = 1024;
    localparam int MAX_COLS        = 1024;
    localparam int DIM_RESET       = 1024;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 1'b1;

    localparam logic OP_SET = 1'b0;
    localparam logic OP_GET = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_DRAIN,
        S_DECIDE
    } t_state;

    typedef struct packed {
        logic load;
        logic scan_init;
        logic scan_rd;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic range_err;
        logic count_zero;
        logic last_addr;
    } t_flags;

endpackage

// ===== rtl/core/smes_ram.sv =====
module smes_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/smes_ctrl.sv =====
module smes_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  smes_pkg::t_flags i_flags,
    output smes_pkg::t_cmd  o_cmd,
    output logic            o_busy
);

    smes_pkg::t_state r_state;
    smes_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smes_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            smes_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = smes_pkg::S_CHECK;
                end
            end
            smes_pkg::S_CHECK: begin
                o_cmd.scan_init = 1'b1;
                // Rejected items and an empty table need no scan.
                if (i_flags.range_err || i_flags.count_zero) begin
                    n_state = smes_pkg::S_DECIDE;
                end else begin
                    n_state = smes_pkg::S_SCAN;
                end
            end
            smes_pkg::S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_flags.last_addr) begin
                    n_state = smes_pkg::S_DRAIN;
                end
            end
            smes_pkg::S_DRAIN: begin
                n_state = smes_pkg::S_DECIDE;
            end
            smes_pkg::S_DECIDE: begin
                o_cmd.finish = 1'b1;
                n_state      = smes_pkg::S_IDLE;
            end
            default: begin
                n_state = smes_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != smes_pkg::S_IDLE);

endmodule

// ===== rtl/core/smes_datapath.sv =====
module smes_datapath #(
    parameter int ENTRIES = smes_pkg::ENTRIES_DEFAULT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  smes_pkg::t_cmd                       i_cmd,
    output smes_pkg::t_flags                     o_flags,
    input  logic                                 i_cfg_we,
    input  logic [smes_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [smes_pkg::DIM_W-1:0]           i_cfg_data,
    input  logic                                 i_op,
    input  logic [smes_pkg::ROW_W-1:0]           i_row_index,
    input  logic [smes_pkg::COL_W-1:0]           i_col_index,
    input  logic signed [smes_pkg::VAL_W-1:0]    i_value,
    output logic                                 o_valid,
    output logic signed [smes_pkg::VAL_W-1:0]    o_read_value,
    output logic [1:0]                           o_status
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int RW = smes_pkg::ROW_W;
    localparam int KW = smes_pkg::COL_W;
    localparam int VW = smes_pkg::VAL_W;
    localparam int DW = smes_pkg::DIM_W;
    localparam int EW = smes_pkg::ENTRY_W;

    logic [DW-1:0] r_rows_in_use;
    logic [DW-1:0] r_cols_in_use;

    logic                 r_op;
    logic [RW-1:0]        r_row;
    logic [KW-1:0]        r_col;
    logic signed [VW-1:0] r_value;

    logic [CW-1:0]        r_count;
    logic [AW-1:0]        r_addr;
    logic                 r_cmp_valid;
    logic [AW-1:0]        r_cmp_idx;
    logic                 r_hit;
    logic [AW-1:0]        r_hit_idx;
    logic signed [VW-1:0] r_hit_value;

    logic                 r_valid;
    logic signed [VW-1:0] r_read_value;
    smes_pkg::t_status    r_status;

    logic [DW-1:0] row_lim;
    logic [DW-1:0] col_lim;
    logic          range_err;
    logic          full;
    logic          match;
    logic [EW-1:0] rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;

    assign row_lim = (r_rows_in_use > DW'(smes_pkg::MAX_ROWS)) ?
                     DW'(smes_pkg::MAX_ROWS) : r_rows_in_use;
    assign col_lim = (r_cols_in_use > DW'(smes_pkg::MAX_COLS)) ?
                     DW'(smes_pkg::MAX_COLS) : r_cols_in_use;
    assign range_err = ({1'b0, r_row} >= row_lim) || ({1'b0, r_col} >= col_lim);
    assign full      = (r_count == CW'(ENTRIES));

    assign match = r_cmp_valid
                && (rd_data[EW-1 -: RW] == r_row)
                && (rd_data[VW +: KW] == r_col);

    assign o_flags.range_err  = range_err;
    assign o_flags.count_zero = (r_count == '0);
    assign o_flags.last_addr  = ((CW'(r_addr) + CW'(1)) == r_count);

    // A set updates the matching entry, or appends at the fill count if the table is not full.
    assign wr_en   = i_cmd.finish && !range_err && (r_op == smes_pkg::OP_SET)
                  && (r_hit || !full);
    assign wr_addr = r_hit ? r_hit_idx : r_count[AW-1:0];

    smes_ram #(
        .WIDTH(EW),
        .DEPTH(ENTRIES)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data({r_row, r_col, r_value}),
        .i_rd_en  (i_cmd.scan_rd),
        .i_rd_addr(r_addr),
        .o_rd_data(rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_in_use <= DW'(smes_pkg::DIM_RESET);
            r_cols_in_use <= DW'(smes_pkg::DIM_RESET);
            r_count       <= '0;
            r_cmp_valid   <= 1'b0;
            r_hit         <= 1'b0;
            r_valid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    smes_pkg::REG_ROWS_IN_USE: r_rows_in_use <= i_cfg_data;
                    smes_pkg::REG_COLS_IN_USE: r_cols_in_use <= i_cfg_data;
                    default: ;
                endcase
            end
            if (wr_en && !r_hit) begin
                r_count <= r_count + CW'(1);
            end
            r_cmp_valid <= i_cmd.scan_rd;
            if (i_cmd.scan_init) begin
                r_hit <= 1'b0;
            end else if (match) begin
                r_hit <= 1'b1;
            end
            r_valid <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_row   <= i_row_index;
            r_col   <= i_col_index;
            r_value <= i_value;
        end
        if (i_cmd.scan_init) begin
            r_addr <= '0;
        end else if (i_cmd.scan_rd) begin
            r_addr <= r_addr + AW'(1);
        end
        r_cmp_idx <= r_addr;
        if (match) begin
            r_hit_idx   <= r_cmp_idx;
            r_hit_value <= $signed(rd_data[VW-1:0]);
        end
        if (i_cmd.finish) begin
            r_read_value <= '0;
            r_status     <= smes_pkg::ST_OK;
            if (range_err) begin
                r_status <= smes_pkg::ST_RANGE;
            end else if (r_op == smes_pkg::OP_SET) begin
                if (!r_hit && full) begin
                    r_status <= smes_pkg::ST_FULL;
                end
            end else if (r_hit) begin
                r_read_value <= r_hit_value;
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_read_value = r_read_value;
    assign o_status     = r_status;

endmodule

// ===== rtl/core/sparse_matrix_entry_store.sv =====
// Channel     Direction  Handshake              Payload
// config      in         i_cfg_we               i_cfg_idx, i_cfg_data
// command     in         i_start / o_busy       i_op, i_row_index, i_col_index, i_value
// result      out        o_valid (strobe)       o_read_value, o_status
//
// A command transfer happens at a clock edge with i_start high and o_busy low.
// A rejected index, or any command while the table is empty, skips the scan:
// the controller goes from check to decide. Otherwise the single read port of
// the entry memory scans every filled entry (at most ENTRIES), one per cycle,
// followed by the drain and decide states; the result is registered from decide.
// The next command can be taken in the cycle the result is shown.
// Synchronous reset empties the table at once through the fill count; no
// clearing pass runs. The receiver cannot stall: o_valid is high one cycle.
module sparse_matrix_entry_store #(
    parameter int ENTRIES = smes_pkg::ENTRIES_DEFAULT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [smes_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [smes_pkg::DIM_W-1:0]           i_cfg_data,
    input  logic                                 i_start,
    output logic                                 o_busy,
    input  logic                                 i_op,
    input  logic [smes_pkg::ROW_W-1:0]           i_row_index,
    input  logic [smes_pkg::COL_W-1:0]           i_col_index,
    input  logic signed [smes_pkg::VAL_W-1:0]    i_value,
    output logic                                 o_valid,
    output logic signed [smes_pkg::VAL_W-1:0]    o_read_value,
    output logic [1:0]                           o_status
);

    `include "sparse_matrix_entry_store_defines.svh"

    // Commands from the controller to the datapath, and the flags it uses
    // to pick the next step.
    smes_pkg::t_cmd   cmd;
    smes_pkg::t_flags flags;

    // The controller walks each command through check and decide, with scan and
    // drain between them unless the scan is skipped; the busy output is simply "not idle".
    smes_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .i_flags(flags),
        .o_cmd  (cmd),
        .o_busy (o_busy)
    );

    // The datapath holds the dimension registers, the captured command, the
    // entry memory with its fill count, the compare stage behind the memory
    // read, and the result registers.
    smes_datapath #(
        .ENTRIES(ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_flags     (flags),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_op        (i_op),
        .i_row_index (i_row_index),
        .i_col_index (i_col_index),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .o_read_value(o_read_value),
        .o_status    (o_status)
    );

    // The result strobe only appears once the controller is back in idle.
    `SMES_ASSERT_SAME(a_valid_idle, i_clk, i_rst_n, o_valid, !o_busy,
        "result shown while busy")

    // Every command passes through check and decide before idle, so strobes never touch.
    `SMES_ASSERT_NEXT(a_single_strobe, i_clk, i_rst_n, o_valid, !o_valid,
        "result strobe longer than one cycle")

    // A transfer always moves the controller out of idle.
    `SMES_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy,
        "command transfer did not start work")

    // Only a successful lookup returns a nonzero value.
    `SMES_ASSERT_SAME(a_value_ok, i_clk, i_rst_n, o_valid && (o_read_value != '0),
        o_status == smes_pkg::ST_OK, "nonzero value with error status")

endmodule
